[rtl/core/assert_macros.svh]
// assertion macros used by the checker of the execute unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, idle while arst_n is low
`define CPUEX_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpuex: same-cycle check failed");

// next-cycle implication, sampled on clk, idle while arst_n is low
`define CPUEX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpuex: next-cycle check failed");

`endif

[rtl/core/cpuex_pkg.sv]
// types and constants of the 8-bit execute unit
package cpuex_pkg;

	// operation classes
	typedef enum logic [3:0] {
		ACT_NOP       = 4'd0,
		ACT_MEM       = 4'd1,
		ACT_INCDEC    = 4'd2,
		ACT_JMPSET    = 4'd3,
		ACT_JMPCLR    = 4'd4,
		ACT_CMPTEST   = 4'd5,
		ACT_ADDSUB    = 4'd6,
		ACT_ADDSUBIMM = 4'd7,
		ACT_NOT       = 4'd8,
		ACT_ANDOR     = 4'd9,
		ACT_XOR       = 4'd10,
		ACT_ROTSHIFT  = 4'd11,
		ACT_STACK     = 4'd12,
		ACT_CALLRET   = 4'd13,
		ACT_LDI       = 4'd14,
		ACT_MOV       = 4'd15
	} action_t;

	// flag bit positions
	localparam int FLAG_S = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_C = 1;
	localparam int FLAG_V = 0;

	// operand code that loads the accumulator in a load immediate
	localparam logic [3:0] LDI_ACC = 4'b1000;

	// overflow boundaries of increment and decrement
	localparam logic [7:0] INC_OVF = 8'h80;
	localparam logic [7:0] DEC_OVF = 8'h7f;

	// instruction and machine state seen by the execute logic
	typedef struct packed {
		action_t         action;
		logic [3:0]      operand;
		logic [7:0]      byte_arg;
		logic [7:0]      next_pc;
		logic [7:0]      acc;
		logic [7:0][7:0] regs;
		logic [3:0]      flags;
		logic [7:0]      mem_rd;
		logic [7:0]      stk_rd;
		logic            stk_empty;
		logic            stk_full;
	} exec_in_t;

	// new state and side effects of one instruction
	typedef struct packed {
		logic [7:0] pc;
		logic [7:0] acc;
		logic [3:0] flags;
		logic       fault;
		logic       reg_we;
		logic [2:0] reg_idx;
		logic [7:0] reg_wdata;
		logic       mem_we;
		logic [7:0] mem_wdata;
		logic       push;
		logic [7:0] push_data;
		logic       pop;
	} exec_out_t;

endpackage

[rtl/core/cpuex_alu.sv]
// combinational execute logic: one instruction against the current state
module cpuex_alu (
	input  cpuex_pkg::exec_in_t  ex_in,
	output cpuex_pkg::exec_out_t ex_out
);

	// add or subtract, returns {carry, overflow, result}
	function automatic logic [9:0] arith(input logic [7:0] a, input logic [7:0] b,
			input logic sub);
		logic [8:0] sum;
		logic       c;
		logic       v;
		if (sub) begin
			sum = {1'b0, a} + {1'b0, ~b} + 9'd1;
			c   = (a < b);
			v   = (a[7] != b[7]) && (sum[7] != a[7]);
		end else begin
			sum = {1'b0, a} + {1'b0, b};
			c   = sum[8];
			v   = (a[7] == b[7]) && (sum[7] != a[7]);
		end
		return {c, v, sum[7:0]};
	endfunction

	// sign and zero of a byte, returns {s, z}
	function automatic logic [1:0] sz(input logic [7:0] v);
		return {v[7], (v == 8'd0)};
	endfunction

	logic [2:0] r;
	logic       d;
	logic       b0;
	logic [7:0] rv;
	logic [7:0] acc;
	logic [3:0] fl;
	logic [7:0] val;
	logic [9:0] ar;
	logic       rot;
	logic       msb;

	assign r   = ex_in.operand[2:0];
	assign d   = ex_in.operand[3];
	assign b0  = ex_in.operand[0];
	assign rv  = ex_in.regs[r];
	assign acc = ex_in.acc;
	assign fl  = ex_in.flags;
	assign rot = !ex_in.operand[1];

	// shared arithmetic for compare, add/sub and immediate add/sub
	always_comb begin
		case (ex_in.action)
			cpuex_pkg::ACT_ADDSUB:    ar = arith(acc, rv, d);
			cpuex_pkg::ACT_ADDSUBIMM: ar = arith(acc, ex_in.byte_arg, b0);
			default:                  ar = arith(acc, rv, 1'b1);
		endcase
	end

	// shift-in bit for a right shift or rotate
	assign msb = (ex_in.operand[2] && !rot && acc[7]) || (rot && fl[cpuex_pkg::FLAG_C]);

	// per-class result
	always_comb begin
		ex_out           = '0;
		ex_out.pc        = ex_in.next_pc;
		ex_out.acc       = acc;
		ex_out.flags     = fl;
		ex_out.reg_idx   = r;
		ex_out.push_data = (r != 3'd0) ? rv : acc;
		ex_out.mem_wdata = (r != 3'd0) ? rv : acc;
		val              = 8'd0;
		case (ex_in.action)
			cpuex_pkg::ACT_MEM: begin
				if (d) begin
					if (r != 3'd0) begin
						ex_out.reg_we    = 1'b1;
						ex_out.reg_wdata = ex_in.mem_rd;
					end else begin
						ex_out.acc = ex_in.mem_rd;
					end
				end else begin
					ex_out.mem_we = 1'b1;
				end
			end
			cpuex_pkg::ACT_INCDEC: begin
				val              = d ? rv - 8'd1 : rv + 8'd1;
				ex_out.reg_we    = 1'b1;
				ex_out.reg_wdata = val;
				ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(val);
				ex_out.flags[cpuex_pkg::FLAG_V] = d ? (val == cpuex_pkg::DEC_OVF) :
					(val == cpuex_pkg::INC_OVF);
			end
			cpuex_pkg::ACT_JMPSET: begin
				if ((ex_in.operand & fl) != 4'd0) ex_out.pc = ex_in.byte_arg;
			end
			cpuex_pkg::ACT_JMPCLR: begin
				if ((ex_in.operand & fl) == 4'd0) ex_out.pc = ex_in.byte_arg;
			end
			cpuex_pkg::ACT_CMPTEST: begin
				if (d) begin
					ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(rv & acc);
				end else begin
					ex_out.flags = {sz(ar[7:0]), ar[9], ar[8]};
				end
			end
			cpuex_pkg::ACT_ADDSUB, cpuex_pkg::ACT_ADDSUBIMM: begin
				ex_out.acc   = ar[7:0];
				ex_out.flags = {sz(ar[7:0]), ar[9], ar[8]};
			end
			cpuex_pkg::ACT_NOT: begin
				val        = b0 ? (~acc + 8'd1) : ~acc;
				ex_out.acc = val;
				ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(val);
			end
			cpuex_pkg::ACT_ANDOR: begin
				val        = d ? (acc | rv) : (acc & rv);
				ex_out.acc = val;
				ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(val);
			end
			cpuex_pkg::ACT_XOR: begin
				val        = d ? (acc ^ (8'd1 << r)) : (acc ^ rv);
				ex_out.acc = val;
				ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(val);
			end
			cpuex_pkg::ACT_ROTSHIFT: begin
				if (b0) begin
					val = {msb, acc[7:1]};
					ex_out.flags[cpuex_pkg::FLAG_C] = acc[0];
				end else begin
					val = {acc[6:0], rot && fl[cpuex_pkg::FLAG_C]};
					ex_out.flags[cpuex_pkg::FLAG_C] = acc[7];
				end
				ex_out.acc = val;
				ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(val);
			end
			cpuex_pkg::ACT_STACK: begin
				if (d) begin
					if (ex_in.stk_empty) begin
						ex_out.fault = 1'b1;
					end else begin
						ex_out.pop = 1'b1;
						if (r != 3'd0) begin
							ex_out.reg_we    = 1'b1;
							ex_out.reg_wdata = ex_in.stk_rd;
						end else begin
							ex_out.acc = ex_in.stk_rd;
							ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] =
								sz(ex_in.stk_rd);
						end
					end
				end else begin
					if (ex_in.stk_full) ex_out.fault = 1'b1;
					else ex_out.push = 1'b1;
				end
			end
			cpuex_pkg::ACT_CALLRET: begin
				if (b0) begin
					if (ex_in.stk_empty) begin
						ex_out.fault = 1'b1;
					end else begin
						ex_out.pop = 1'b1;
						ex_out.pc  = ex_in.stk_rd;
					end
				end else begin
					ex_out.push_data = ex_in.next_pc;
					if (ex_in.stk_full) begin
						ex_out.fault = 1'b1;
					end else begin
						ex_out.push = 1'b1;
						ex_out.pc   = ex_in.byte_arg;
					end
				end
			end
			cpuex_pkg::ACT_LDI: begin
				if (ex_in.operand == cpuex_pkg::LDI_ACC) begin
					ex_out.acc = ex_in.byte_arg;
					ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(ex_in.byte_arg);
				end else if (!d) begin
					ex_out.reg_we    = 1'b1;
					ex_out.reg_wdata = ex_in.byte_arg;
				end
			end
			cpuex_pkg::ACT_MOV: begin
				if (d) begin
					ex_out.acc = rv;
					ex_out.flags[cpuex_pkg::FLAG_S:cpuex_pkg::FLAG_Z] = sz(rv);
				end else begin
					ex_out.reg_we    = 1'b1;
					ex_out.reg_wdata = acc;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/eight_bit_cpu_execute_unit.sv]
// top level of the 8-bit execute unit: state, memories and handshakes
// One decoded instruction per clock while the result side does not stall: a
// request is registered in the request stage, then executed against the
// accumulator, register file, flags, data memory and call stack, and its
// result is registered in the output register. Requests are taken every cycle
// unless a waiting result is stalled; the pace is set by the single execute
// stage, whose data memory and stack-top reads are registered ahead of use
// with write bypass so that back-to-back loads, pushes and pops see fresh data.
// acc_value and flag_bits are the architectural registers themselves and hold
// while a result waits. Data memory and stack contents are not cleared by
// reset; no clearing pass is needed, so requests are taken straight after reset.
module eight_bit_cpu_execute_unit #(
	parameter int MEM_DEPTH   = 256,
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [3:0] action,
	input  logic [3:0] operand,
	input  logic [7:0] byte_arg,
	input  logic [7:0] next_pc,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] pc,
	output logic [7:0] acc_value,
	output logic [3:0] flag_bits,
	output logic       stack_fault
);

	localparam int MA_W = $clog2(MEM_DEPTH);
	localparam int SI_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	// register 0 reduced to a data memory index by conditional subtraction
	function automatic logic [MA_W-1:0] mem_index(input logic [7:0] v);
		logic [8:0] x;
		x = {1'b0, v};
		for (int k = 3; k >= 0; k--) begin
			if (int'(x) >= (MEM_DEPTH << k)) x = x - 9'(MEM_DEPTH << k);
		end
		return x[MA_W-1:0];
	endfunction

	// request stage
	logic            valid_s1;
	logic [3:0]      action_s1;
	logic [3:0]      operand_s1;
	logic [7:0]      byte_arg_s1;
	logic [7:0]      next_pc_s1;

	// machine state
	logic [7:0]      acc_q;
	logic [7:0][7:0] regs_q;
	logic [3:0]      flags_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]      mem_q [MEM_DEPTH];
	logic [7:0]      stk_q [STACK_DEPTH];
	logic [7:0]      mem_rd_q;
	logic [7:0]      stk_rd_q;

	// result register
	logic            res_valid_q;
	logic [7:0]      pc_q;
	logic            fault_q;

	logic                 advance;
	logic                 exec;
	logic                 accept;
	cpuex_pkg::exec_in_t  ex_in;
	cpuex_pkg::exec_out_t ex_out;
	logic [7:0]           reg0_next;
	logic                 mem_we;
	logic [MA_W-1:0]      mem_waddr;
	logic [MA_W-1:0]      mem_raddr;
	logic                 push;
	logic                 pop;
	logic [SP_W-1:0]      sp_next;
	logic [SP_W-1:0]      sp_top;

	// handshake control
	assign advance   = !res_valid_q || !res_stall;
	assign exec      = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	// execute logic
	always_comb begin
		ex_in.action    = cpuex_pkg::action_t'(action_s1);
		ex_in.operand   = operand_s1;
		ex_in.byte_arg  = byte_arg_s1;
		ex_in.next_pc   = next_pc_s1;
		ex_in.acc       = acc_q;
		ex_in.regs      = regs_q;
		ex_in.flags     = flags_q;
		ex_in.mem_rd    = mem_rd_q;
		ex_in.stk_rd    = stk_rd_q;
		ex_in.stk_empty = (sp_q == '0);
		ex_in.stk_full  = (sp_q == SP_W'(STACK_DEPTH));
	end

	cpuex_alu u_alu (
		.ex_in  (ex_in),
		.ex_out (ex_out)
	);

	// next register 0 and stack pointer, for the look-ahead reads
	assign reg0_next = (exec && ex_out.reg_we && ex_out.reg_idx == 3'd0) ?
		ex_out.reg_wdata : regs_q[0];
	assign mem_we    = exec && ex_out.mem_we;
	assign mem_waddr = mem_index(regs_q[0]);
	assign mem_raddr = mem_index(reg0_next);
	assign push      = exec && ex_out.push;
	assign pop       = exec && ex_out.pop;
	assign sp_next   = push ? sp_q + SP_W'(1) : (pop ? sp_q - SP_W'(1) : sp_q);
	assign sp_top    = sp_next - SP_W'(1);

	// request stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action;
			operand_s1  <= operand;
			byte_arg_s1 <= byte_arg;
			next_pc_s1  <= next_pc;
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			regs_q  <= '0;
			flags_q <= '0;
			sp_q    <= '0;
		end else if (exec) begin
			acc_q   <= ex_out.acc;
			flags_q <= ex_out.flags;
			sp_q    <= sp_next;
			if (ex_out.reg_we) regs_q[ex_out.reg_idx] <= ex_out.reg_wdata;
		end
	end

	// data memory with registered read of the next register 0 address
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= ex_out.mem_wdata;
		if (mem_we && mem_waddr == mem_raddr) mem_rd_q <= ex_out.mem_wdata;
		else mem_rd_q <= mem_q[mem_raddr];
	end

	// call stack with registered read of the next top entry
	always_ff @(posedge clk) begin
		if (push) stk_q[sp_q[SI_W-1:0]] <= ex_out.push_data;
		if (push && sp_q[SI_W-1:0] == sp_top[SI_W-1:0]) stk_rd_q <= ex_out.push_data;
		else stk_rd_q <= stk_q[sp_top[SI_W-1:0]];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			pc_q    <= ex_out.pc;
			fault_q <= ex_out.fault;
		end
	end

	assign res_valid   = res_valid_q;
	assign pc          = pc_q;
	assign acc_value   = acc_q;
	assign flag_bits   = flags_q;
	assign stack_fault = fault_q;

endmodule

[rtl/core/cpuex_checker.sv]
// port-level checks of the execute unit and their binding
`include "assert_macros.svh"

module cpuex_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [3:0] action,
	input logic [3:0] operand,
	input logic [7:0] byte_arg,
	input logic [7:0] next_pc,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] pc,
	input logic [7:0] acc_value,
	input logic [3:0] flag_bits,
	input logic       stack_fault
);

	// a waiting result holds its payload
	`CPUEX_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
		res_valid && $stable(pc) && $stable(acc_value) && $stable(flag_bits) && $stable(stack_fault))

	// requests are only held back by a stalled result
	`CPUEX_ASSERT_IMPLY(a_req_backpressure, req_stall, res_valid && res_stall)

	// accumulator and flags change only together with a new result
	`CPUEX_ASSERT_NEXT(a_state_quiet, !res_valid, res_valid || ($stable(acc_value) && $stable(flag_bits)))

	// a refused stack request leaves accumulator and flags alone
	`CPUEX_ASSERT_IMPLY(a_fault_keeps_state,
		res_valid && stack_fault && (!$past(res_valid) || !$past(res_stall)),
		$stable(acc_value) && $stable(flag_bits))

endmodule

bind eight_bit_cpu_execute_unit cpuex_checker u_cpuex_checker (.*);
